FILE: hdl/igtt_pkg.sv
// shared constants for the iou greedy track table
package igtt_pkg;

  localparam int unsigned MaxTracksDefault = 16;
  localparam int unsigned CoordBitsDefault = 12;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegMaxLost = 8'd0;
  localparam logic [CfgIdxW-1:0] RegIouThr  = 8'd1;

  localparam logic [7:0] MaxLostReset = 8'd30;
  localparam logic [6:0] IouThrReset  = 7'd10;

  localparam int unsigned LostW   = 9;
  localparam logic [8:0]  LostMax = 9'd511;

  localparam int unsigned IdW     = 16;
  localparam int unsigned CountW  = 5;
  localparam logic [6:0]  PctFull = 7'd100;

endpackage

FILE: hdl/iou_greedy_track_table.sv
// iou greedy track table: compacted track store with a shared multiplier sequencer
// detection: the detection area, then per unmatched valid track (matched ones are
//   skipped) bound, intersection, track area, union and two cross products, then
//   the threshold check, commit and result register; one multiplier does all
//   area and cross products; end of frame ages and compacts each valid track
// one item at a time; the next item is taken once the result is registered
// rst_ni clears the table, matched marks, id counter and the registers to their defaults
module iou_greedy_track_table #(
  parameter int unsigned MAX_TRACKS = igtt_pkg::MaxTracksDefault,
  parameter int unsigned COORD_BITS = igtt_pkg::CoordBitsDefault,
  localparam int unsigned InW = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // det_x, det_y, det_w, det_h
  input  logic [InW-1:0]                s_axis_tdata_i,
  // command
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // assigned_id, track_count, primary_id
  output logic [39:0]                   m_axis_tdata_o,
  // is_new_track, dropped, primary_valid
  output logic [2:0]                    m_axis_tuser_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [igtt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [igtt_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned AreaW = 2 * C;
  localparam int unsigned UnW   = 2 * C + 1;
  localparam int unsigned PW    = 2 * UnW;
  localparam int unsigned CntW  = $clog2(MAX_TRACKS + 1);
  localparam int unsigned IdxW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned IdW   = igtt_pkg::IdW;
  localparam int unsigned LostW = igtt_pkg::LostW;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DAREA = 12'b000000000010,
    S_BOUND = 12'b000000000100,
    S_INTER = 12'b000000001000,
    S_TAREA = 12'b000000010000,
    S_UNION = 12'b000000100000,
    S_P1    = 12'b000001000000,
    S_P2    = 12'b000010000000,
    S_THR1  = 12'b000100000000,
    S_THR2  = 12'b001000000000,
    S_COMIT = 12'b010000000000,
    S_AGE   = 12'b100000000000
  } state_e;

  state_e state_q;
  logic   fin_q;

  // configuration
  logic [7:0] max_lost_q;
  logic [6:0] thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lost_q <= igtt_pkg::MaxLostReset;
      thr_q      <= igtt_pkg::IouThrReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        igtt_pkg::RegMaxLost: max_lost_q <= cfg_data_i;
        igtt_pkg::RegIouThr:  thr_q      <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // track store
  logic [C-1:0]     tx_q [MAX_TRACKS];
  logic [C-1:0]     ty_q [MAX_TRACKS];
  logic [C-1:0]     tw_q [MAX_TRACKS];
  logic [C-1:0]     th_q [MAX_TRACKS];
  logic [IdW-1:0]   tid_q [MAX_TRACKS];
  logic [LostW-1:0] lost_q [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] matched_q;
  logic [CntW-1:0]  count_q;
  logic [IdW-1:0]   next_id_q;

  // per item work registers
  logic [C-1:0]     dx_q, dy_q, dw_q, dh_q;
  logic [CntW-1:0]  i_q, wr_q;
  logic [C-1:0]     iw_q, ih_q;
  logic [AreaW-1:0] darea_q, tarea_q, inter_q, cint_q, bint_q;
  logic [UnW-1:0]   cun_q, bun_q;
  logic [PW-1:0]    p1_q;
  logic             found_q, match_q;
  logic [IdxW-1:0]  best_q;

  // finished item, waiting for the result register
  logic [IdW-1:0]   pend_aid_q;
  logic             pend_new_q, pend_drop_q;

  // result register
  logic             out_valid_q;
  logic [IdW-1:0]   res_aid_q, res_pid_q;
  logic             res_new_q, res_drop_q, res_pv_q;
  logic [igtt_pkg::CountW-1:0] res_cnt_q;

  logic [IdxW-1:0] ri, wi, ci;
  assign ri = i_q[IdxW-1:0];
  assign wi = wr_q[IdxW-1:0];
  assign ci = count_q[IdxW-1:0];

  // shared multiplier
  logic [UnW-1:0] mul_a, mul_b;
  logic [PW-1:0]  prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_DAREA: begin
        mul_a = UnW'(dw_q);
        mul_b = UnW'(dh_q);
      end
      S_INTER: begin
        mul_a = UnW'(iw_q);
        mul_b = UnW'(ih_q);
      end
      S_TAREA: begin
        mul_a = UnW'(tw_q[ri]);
        mul_b = UnW'(th_q[ri]);
      end
      S_P1: begin
        mul_a = UnW'(cint_q);
        mul_b = bun_q;
      end
      S_P2: begin
        mul_a = UnW'(bint_q);
        mul_b = cun_q;
      end
      S_THR1: begin
        mul_a = UnW'(bint_q);
        mul_b = UnW'(igtt_pkg::PctFull);
      end
      S_THR2: begin
        mul_a = UnW'(thr_q);
        mul_b = bun_q;
      end
      default: ;
    endcase
  end
  assign prod = PW'(mul_a) * PW'(mul_b);

  // overlap bounds of the current slot against the detection
  logic [C:0]   ax1, ay1, ax2, ay2, bx2, by2, x1, y1, x2, y2;
  logic [C-1:0] iw, ih;
  logic [UnW-1:0] un;

  always_comb begin
    ax1 = {1'b0, tx_q[ri]};
    ay1 = {1'b0, ty_q[ri]};
    ax2 = ax1 + {1'b0, tw_q[ri]};
    ay2 = ay1 + {1'b0, th_q[ri]};
    bx2 = {1'b0, dx_q} + {1'b0, dw_q};
    by2 = {1'b0, dy_q} + {1'b0, dh_q};
    x1 = (ax1 > {1'b0, dx_q}) ? ax1 : {1'b0, dx_q};
    y1 = (ay1 > {1'b0, dy_q}) ? ay1 : {1'b0, dy_q};
    x2 = (ax2 < bx2) ? ax2 : bx2;
    y2 = (ay2 < by2) ? ay2 : by2;
    iw = (x2 > x1) ? C'(x2 - x1) : '0;
    ih = (y2 > y1) ? C'(y2 - y1) : '0;
    un = UnW'(tarea_q) + UnW'(darea_q) - UnW'(inter_q);
  end

  // ageing of the slot under the read pointer
  logic [LostW-1:0] aged;
  assign aged = (!matched_q[ri] && lost_q[ri] < igtt_pkg::LostMax) ?
                lost_q[ri] + LostW'(1) : lost_q[ri];

  logic keep;
  assign keep = aged <= LostW'(max_lost_q);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE) && !fin_q;

  logic full;
  assign full = count_q >= CntW'(MAX_TRACKS);

  // store payload, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_AGE: begin
        if (i_q != count_q && keep) begin
          tx_q[wi]   <= tx_q[ri];
          ty_q[wi]   <= ty_q[ri];
          tw_q[wi]   <= tw_q[ri];
          th_q[wi]   <= th_q[ri];
          tid_q[wi]  <= tid_q[ri];
          lost_q[wi] <= aged;
        end
      end
      S_COMIT: begin
        if (match_q) begin
          tx_q[best_q]   <= dx_q;
          ty_q[best_q]   <= dy_q;
          tw_q[best_q]   <= dw_q;
          th_q[best_q]   <= dh_q;
          lost_q[best_q] <= '0;
        end else if (!full) begin
          tx_q[ci]   <= dx_q;
          ty_q[ci]   <= dy_q;
          tw_q[ci]   <= dw_q;
          th_q[ci]   <= dh_q;
          tid_q[ci]  <= next_id_q;
          lost_q[ci] <= '0;
        end
      end
      default: ;
    endcase
  end

  // work registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dx_q  <= s_axis_tdata_i[C-1:0];
      dy_q  <= s_axis_tdata_i[2*C-1:C];
      dw_q  <= s_axis_tdata_i[3*C-1:2*C];
      dh_q  <= s_axis_tdata_i[4*C-1:3*C];
    end
    unique case (state_q)
      S_DAREA: begin
        darea_q <= AreaW'(prod);
        bint_q  <= '0;
        bun_q   <= UnW'(1);
        found_q <= 1'b0;
        best_q  <= '0;
      end
      S_BOUND: begin
        iw_q <= iw;
        ih_q <= ih;
      end
      S_INTER: inter_q <= AreaW'(prod);
      S_TAREA: tarea_q <= AreaW'(prod);
      S_UNION: begin
        // an empty union counts as zero overlap
        if (un == '0) begin
          cint_q <= '0;
          cun_q  <= UnW'(1);
        end else begin
          cint_q <= inter_q;
          cun_q  <= un;
        end
      end
      S_P1: p1_q <= prod;
      S_P2: begin
        if (p1_q > prod) begin
          bint_q  <= cint_q;
          bun_q   <= cun_q;
          best_q  <= ri;
          found_q <= 1'b1;
        end
      end
      S_THR1: begin
        p1_q    <= prod;
        match_q <= 1'b0;
      end
      S_THR2: match_q <= p1_q >= prod;
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fin_q       <= 1'b0;
      i_q         <= '0;
      wr_q        <= '0;
      count_q     <= '0;
      next_id_q   <= '0;
      matched_q   <= '0;
      pend_aid_q  <= '0;
      pend_new_q  <= 1'b0;
      pend_drop_q <= 1'b0;
      out_valid_q <= 1'b0;
      res_aid_q   <= '0;
      res_pid_q   <= '0;
      res_new_q   <= 1'b0;
      res_drop_q  <= 1'b0;
      res_pv_q    <= 1'b0;
      res_cnt_q   <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fin_q && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
        res_aid_q   <= pend_aid_q;
        res_new_q   <= pend_new_q;
        res_drop_q  <= pend_drop_q;
        res_cnt_q   <= igtt_pkg::CountW'(count_q);
        res_pv_q    <= count_q != '0;
        res_pid_q   <= (count_q != '0) ? tid_q[0] : '0;
        fin_q       <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            i_q     <= '0;
            wr_q    <= '0;
            state_q <= s_axis_tuser_i ? S_AGE : S_DAREA;
          end
        end
        S_DAREA: state_q <= S_BOUND;
        S_BOUND: begin
          if (i_q == count_q) begin
            state_q <= S_THR1;
          end else if (matched_q[ri]) begin
            i_q <= i_q + CntW'(1);
          end else begin
            state_q <= S_INTER;
          end
        end
        S_INTER: state_q <= S_TAREA;
        S_TAREA: state_q <= S_UNION;
        S_UNION: state_q <= S_P1;
        S_P1:    state_q <= S_P2;
        S_P2: begin
          i_q     <= i_q + CntW'(1);
          state_q <= S_BOUND;
        end
        S_THR1:  state_q <= found_q ? S_THR2 : S_COMIT;
        S_THR2:  state_q <= S_COMIT;
        S_COMIT: begin
          pend_new_q  <= 1'b0;
          pend_drop_q <= 1'b0;
          pend_aid_q  <= '0;
          if (match_q) begin
            matched_q[best_q] <= 1'b1;
            pend_aid_q        <= tid_q[best_q];
          end else if (!full) begin
            matched_q[ci] <= 1'b1;
            pend_aid_q    <= next_id_q;
            pend_new_q    <= 1'b1;
            next_id_q     <= next_id_q + IdW'(1);
            count_q       <= count_q + CntW'(1);
          end else begin
            pend_drop_q <= 1'b1;
          end
          fin_q   <= 1'b1;
          state_q <= S_IDLE;
        end
        S_AGE: begin
          if (i_q == count_q) begin
            count_q     <= wr_q;
            matched_q   <= '0;
            pend_aid_q  <= '0;
            pend_new_q  <= 1'b0;
            pend_drop_q <= 1'b0;
            fin_q       <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            if (keep) begin
              wr_q <= wr_q + CntW'(1);
            end
            i_q <= i_q + CntW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, res_pid_q, res_cnt_q, res_aid_q};
  assign m_axis_tuser_o  = {res_pv_q, res_drop_q, res_new_q};

  // table never holds more tracks than slots
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_TRACKS))
    else $error("track count above table size");

  // scan pointer stays within the valid tracks
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (i_q <= count_q))
    else $error("scan pointer past track count");

  // compaction write pointer never overtakes the read pointer
  a_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AGE) |-> (wr_q <= i_q))
    else $error("compaction write ahead of read");

  // an accepted transfer starts work and blocks further input
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready_o)
    else $error("input taken while busy");

endmodule

FILE: tb/tb_iou_greedy_track_table.sv
// self-checking testbench for the iou greedy track table
module tb_iou_greedy_track_table;

  localparam int unsigned NSlots   = 16;
  localparam bit          CmdDet   = 1'b0;
  localparam bit          CmdEof   = 1'b1;
  localparam logic [7:0]  RegSpare = 8'd2;
  localparam int unsigned IdleLim  = 20000;
  localparam int unsigned DrainLen = 150;

  typedef struct packed {
    logic [15:0] aid;
    logic        is_new;
    logic        dropped;
    logic [4:0]  count;
    logic        pvalid;
    logic [15:0] pid;
  } track_res_t;

  class track_scoreboard;
    logic [15:0] ids [NSlots];
    logic [11:0] bx [NSlots];
    logic [11:0] by [NSlots];
    logic [11:0] bw [NSlots];
    logic [11:0] bh [NSlots];
    logic [8:0]  lost [NSlots];
    bit          matched [NSlots];
    int unsigned total;
    logic [15:0] next_id;
    logic [7:0]  max_lost;
    logic [6:0]  thr_pct;
    track_res_t  pending [$];
    int unsigned errors;

    function void clear();
      total = 0;
      next_id = '0;
      max_lost = igtt_pkg::MaxLostReset;
      thr_pct = igtt_pkg::IouThrReset;
      errors = 0;
      foreach (matched[i]) matched[i] = 1'b0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] val);
      if (idx == igtt_pkg::RegMaxLost) max_lost = val;
      else if (idx == igtt_pkg::RegIouThr) thr_pct = val[6:0];
    endfunction

    function void end_frame();
      int unsigned keep;
      keep = 0;
      for (int unsigned i = 0; i < total; i++)
        if (!matched[i] && lost[i] != igtt_pkg::LostMax) lost[i]++;
      for (int unsigned i = 0; i < total; i++) begin
        if (lost[i] <= {1'b0, max_lost}) begin
          ids[keep] = ids[i]; bx[keep] = bx[i]; by[keep] = by[i];
          bw[keep] = bw[i]; bh[keep] = bh[i]; lost[keep] = lost[i];
          keep++;
        end
      end
      total = keep;
      foreach (matched[i]) matched[i] = 1'b0;
    endfunction

    function void note_input(bit cmd, logic [11:0] x, logic [11:0] y,
                             logic [11:0] w, logic [11:0] h);
      track_res_t r;
      longint unsigned x1, y1, x2, y2, iw, ih, it, un, bi, bu;
      int best;
      r = '0;
      if (cmd == CmdEof) begin
        end_frame();
      end else begin
        best = -1;
        bi = 0;
        bu = 1;
        for (int unsigned i = 0; i < total; i++) begin
          if (matched[i]) continue;
          x1 = (bx[i] > x) ? bx[i] : x;
          y1 = (by[i] > y) ? by[i] : y;
          x2 = ((64'(bx[i]) + bw[i]) < (64'(x) + w)) ? 64'(bx[i]) + bw[i] : 64'(x) + w;
          y2 = ((64'(by[i]) + bh[i]) < (64'(y) + h)) ? 64'(by[i]) + bh[i] : 64'(y) + h;
          iw = (x2 > x1) ? x2 - x1 : 0;
          ih = (y2 > y1) ? y2 - y1 : 0;
          it = iw * ih;
          un = 64'(bw[i]) * bh[i] + 64'(w) * h - it;
          if (un == 0) begin
            it = 0;
            un = 1;
          end
          // strict compare keeps the lowest slot on a tie
          if (it * bu > bi * un) begin
            bi = it;
            bu = un;
            best = int'(i);
          end
        end
        if (best >= 0 && bi * 100 >= 64'(thr_pct) * bu) begin
          matched[best] = 1'b1;
          bx[best] = x; by[best] = y; bw[best] = w; bh[best] = h;
          lost[best] = '0;
          r.aid = ids[best];
        end else if (total < NSlots) begin
          matched[total] = 1'b1;
          ids[total] = next_id;
          bx[total] = x; by[total] = y; bw[total] = w; bh[total] = h;
          lost[total] = '0;
          r.aid = next_id;
          r.is_new = 1'b1;
          next_id++;
          total++;
        end else begin
          r.dropped = 1'b1;
        end
      end
      r.count = 5'(total);
      r.pvalid = total > 0;
      r.pid = (total > 0) ? ids[0] : '0;
      pending = {pending, r};
    endfunction

    function void check_result(logic [39:0] data, logic [2:0] user);
      track_res_t e, a;
      a.aid = data[15:0];
      a.count = data[20:16];
      a.pid = data[36:21];
      a.is_new = user[0];
      a.dropped = user[1];
      a.pvalid = user[2];
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending, actual %h", $realtime, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.aid !== e.aid) begin
        $display("%0t: assigned_id expected %0d actual %0d", $realtime, e.aid, a.aid);
        errors++;
      end
      if (a.is_new !== e.is_new) begin
        $display("%0t: is_new_track expected %0d actual %0d", $realtime, e.is_new, a.is_new);
        errors++;
      end
      if (a.dropped !== e.dropped) begin
        $display("%0t: dropped expected %0d actual %0d", $realtime, e.dropped, a.dropped);
        errors++;
      end
      if (a.count !== e.count) begin
        $display("%0t: track_count expected %0d actual %0d", $realtime, e.count, a.count);
        errors++;
      end
      if (a.pvalid !== e.pvalid) begin
        $display("%0t: primary_valid expected %0d actual %0d", $realtime, e.pvalid, a.pvalid);
        errors++;
      end
      if (a.pid !== e.pid) begin
        $display("%0t: primary_id expected %0d actual %0d", $realtime, e.pid, a.pid);
        errors++;
      end
      if (data[39:37] !== 3'b000) begin
        $display("%0t: tdata pad expected 0 actual %0d", $realtime, data[39:37]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  track_scoreboard tracks;
  int unsigned idle_cycles = 0;
  bit          no_gaps = 1'b0;
  int unsigned stall_left = 0;

  iou_greedy_track_table dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 120);
  endfunction

  // result side: random stalls, checked at every transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        tracks.check_result(m_axis_tdata_o, m_axis_tuser_o);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        stall_left <= gap_len();
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLim) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(bit cmd, logic [11:0] x, logic [11:0] y,
                           logic [11:0] w, logic [11:0] h);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {h, w, y, x};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    tracks.note_input(cmd, x, y, w, h);
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (tracks.pending.size() != 0) @(posedge clk_i);
    repeat (DrainLen) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracks.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly a jittered copy of a live track, so matches and ties happen often
  task automatic send_detection();
    int unsigned r, s;
    logic [11:0] x, y, w, h;
    r = $urandom_range(0, 99);
    if (tracks.total > 0 && r < 65) begin
      s = $urandom_range(0, tracks.total - 1);
      x = tracks.bx[s] + 12'($urandom_range(0, 8)) - 12'd4;
      y = tracks.by[s] + 12'($urandom_range(0, 8)) - 12'd4;
      w = tracks.bw[s] + 12'($urandom_range(0, 8));
      h = tracks.bh[s] + 12'($urandom_range(0, 8));
    end else if (r < 85) begin
      x = 12'($urandom_range(0, 600));
      y = 12'($urandom_range(0, 600));
      w = 12'($urandom_range(0, 120));
      h = 12'($urandom_range(0, 120));
    end else begin
      x = 12'($urandom); y = 12'($urandom);
      w = 12'($urandom); h = 12'($urandom);
    end
    send_item(CmdDet, x, y, w, h);
  endtask

  initial begin
    tracks = new();
    tracks.clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset registers first
    send_item(CmdEof, '0, '0, '0, '0);
    send_item(CmdDet, 12'd100, 12'd100, 12'd50, 12'd50);
    send_item(CmdDet, 12'd100, 12'd100, 12'd50, 12'd50);   // first track already matched
    send_item(CmdEof, '0, '0, '0, '0);
    send_item(CmdDet, 12'd100, 12'd100, 12'd50, 12'd50);   // tie, lowest slot wins
    send_item(CmdDet, 12'd110, 12'd105, 12'd50, 12'd50);
    send_item(CmdDet, 12'd0, 12'd0, 12'd0, 12'd0);         // empty box
    send_item(CmdDet, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    send_item(CmdDet, 12'd3000, 12'd3000, 12'd10, 12'd10); // disjoint
    send_item(CmdEof, '0, '0, '0, '0);
    for (int i = 0; i < 12; i++)
      send_item(CmdDet, 12'(i * 200 + 1000), 12'd50, 12'd20, 12'd20);
    send_item(CmdEof, '0, '0, '0, '0);
    drain();

    write_reg(igtt_pkg::RegMaxLost, 8'd0);
    write_reg(igtt_pkg::RegIouThr, 8'd0);
    write_reg(RegSpare, 8'hff);
    send_item(CmdDet, 12'd0, 12'd0, 12'd0, 12'd0);         // zero iou at threshold zero
    send_item(CmdEof, '0, '0, '0, '0);
    send_item(CmdEof, '0, '0, '0, '0);                     // ages out every idle track
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          write_reg(igtt_pkg::RegMaxLost, 8'd255);
          write_reg(igtt_pkg::RegIouThr, 8'd100);
        end
        1: begin
          write_reg(igtt_pkg::RegMaxLost, 8'd2);
          write_reg(igtt_pkg::RegIouThr, 8'hff);
        end
        2: begin
          write_reg(igtt_pkg::RegMaxLost, 8'd30);
          write_reg(igtt_pkg::RegIouThr, 8'd10);
        end
        3: begin
          write_reg(igtt_pkg::RegMaxLost, 8'd0);
          write_reg(igtt_pkg::RegIouThr, 8'd50);
        end
        default: begin
          write_reg(igtt_pkg::RegMaxLost, 8'($urandom_range(0, 8)));
          write_reg(igtt_pkg::RegIouThr, 8'($urandom_range(0, 127)));
        end
      endcase
      no_gaps = (phase % 3 == 1);
      for (int n = 0; n < 140; n++) begin
        if ($urandom_range(0, 4) == 0) send_item(CmdEof, 12'($urandom), 12'($urandom),
                                                 12'($urandom), 12'($urandom));
        else send_detection();
        if (n == 70 && phase == 4) begin
          s_axis_tvalid_i <= 1'b0;
          while (tracks.pending.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (tracks.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
